// ----- rtl/core/arpc_pkg.sv -----
// Shared types and codes for the ARP address cache.
// Used by arpc_cell and the arp_address_cache top level.
`default_nettype none

package arpc_pkg;

  localparam int FUNC_W   = 2;
  localparam int IPV4_W   = 32;
  localparam int MAC_W    = 48;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUT        = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INVALIDATE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // Request token that walks down the row of cells
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IPV4_W-1:0] key;
    logic [MAC_W-1:0]  mac;
    logic              hit;
    logic              free_seen;
    logic [MAC_W-1:0]  found_mac;
  } tok_t;

  // Allocation write broadcast to all cells at the end of a put
  typedef struct packed {
    logic              en;
    logic [IPV4_W-1:0] key;
    logic [MAC_W-1:0]  mac;
  } alloc_t;

endpackage

`default_nettype wire

// ----- rtl/core/arpc_cell.sv -----
// One table entry of the ARP address cache with its token stage.
// Depends on arpc_pkg for the token and allocation types.
`default_nettype none

module arpc_cell import arpc_pkg::*; #(
  parameter int IDX_W      = 4,
  parameter int CELL_INDEX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire tok_t             in_tok,
  input  wire logic [IDX_W-1:0] in_free_idx,
  input  wire alloc_t           alloc,
  input  wire logic [IDX_W-1:0] alloc_idx,
  output logic                  out_valid,
  output tok_t                  out_tok,
  output logic [IDX_W-1:0]      out_free_idx
);

  logic              entry_valid;
  logic [IPV4_W-1:0] entry_ipv4;
  logic [MAC_W-1:0]  entry_mac;

  logic              match;
  logic              take_free;
  logic              alloc_here;
  tok_t              tok_next;
  logic [IDX_W-1:0]  free_idx_next;

  // Compare the passing key against this entry; first match wins
  assign match      = in_valid && !in_tok.hit && entry_valid && (entry_ipv4 == in_tok.key);
  assign take_free  = in_valid && !entry_valid && !in_tok.free_seen;
  assign alloc_here = alloc.en && (alloc_idx == IDX_W'(CELL_INDEX));

  // Update the token for the next cell
  always_comb begin
    tok_next = in_tok;
    if (match) begin
      tok_next.hit = 1'b1;
      if (in_tok.func == FUNC_LOOKUP) begin
        tok_next.found_mac = entry_mac;
      end
    end
    if (take_free) begin
      tok_next.free_seen = 1'b1;
    end
    free_idx_next = take_free ? IDX_W'(CELL_INDEX) : in_free_idx;
  end

  // Control state: valid mark and token stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= in_valid;
      if (alloc_here) begin
        entry_valid <= 1'b1;
      end else if (match && in_tok.func == FUNC_INVALIDATE) begin
        entry_valid <= 1'b0;
      end
    end
  end

  // Payload: entry contents and token stage
  always_ff @(posedge clk) begin
    out_tok      <= tok_next;
    out_free_idx <= free_idx_next;
    if (alloc_here) begin
      entry_ipv4 <= alloc.key;
      entry_mac  <= alloc.mac;
    end else if (match && in_tok.func == FUNC_PUT) begin
      entry_mac <= in_tok.mac;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/arp_address_cache.sv -----
// ARP address cache: maps IPv4 addresses to MAC addresses in a fixed table.
//
// Input channel (in_valid / in_stall): one word carries func, ipv4_addr and
// mac_addr. func selects put, lookup or invalidate. Output channel
// (out_valid / out_stall): one word per input word carries status and
// mac_found.
// Each accepted word walks down a row of TABLE_ENTRIES cells, one cell per
// cycle; each cell holds one entry and compares it to the passing key. A put
// that found no match is written into the lowest free entry at the end of
// the row. The result passes from the last cell into the hold register and
// then into the output register. One word is in the row at a time: a new
// word is not accepted while the previous one is still in flight.
// A finished result parks in a hold register while the output word waits,
// so the next input word is taken once the previous one reaches the output.
// While out_valid and out_stall are both high, the output word and the hold
// register keep their contents, and in_stall stays high while a result is held.
// Reset (rst, synchronous) clears every entry's valid mark and all handshake
// state; the table is usable the cycle after reset drops.
`default_nettype none

module arp_address_cache import arpc_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [FUNC_W-1:0]   func,
  input  wire logic [IPV4_W-1:0]   ipv4_addr,
  input  wire logic [MAC_W-1:0]    mac_addr,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [MAC_W-1:0]         mac_found
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TABLE_ENTRIES:0] tok_valid;
  tok_t                   tok      [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]       free_idx [0:TABLE_ENTRIES];

  alloc_t                 alloc;
  logic [IDX_W-1:0]       alloc_idx;

  logic                   busy;
  logic                   accept;
  logic                   hold_valid;
  logic [STATUS_W-1:0]    hold_status;
  logic [MAC_W-1:0]       hold_mac;
  logic                   hold_move;
  logic [STATUS_W-1:0]    res_status;
  tok_t                   last;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  // Launch a fresh token into the first cell
  assign tok_valid[0]     = accept;
  assign tok[0].func      = func;
  assign tok[0].key       = ipv4_addr;
  assign tok[0].mac       = mac_addr;
  assign tok[0].hit       = 1'b0;
  assign tok[0].free_seen = 1'b0;
  assign tok[0].found_mac = '0;
  assign free_idx[0]      = '0;

  // Row of entry cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    arpc_cell #(
      .IDX_W      (IDX_W),
      .CELL_INDEX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .in_valid     (tok_valid[i]),
      .in_tok       (tok[i]),
      .in_free_idx  (free_idx[i]),
      .alloc        (alloc),
      .alloc_idx    (alloc_idx),
      .out_valid    (tok_valid[i+1]),
      .out_tok      (tok[i+1]),
      .out_free_idx (free_idx[i+1])
    );
  end

  assign last = tok[TABLE_ENTRIES];

  // Allocate the lowest free entry for a put that matched nothing
  assign alloc.en  = tok_valid[TABLE_ENTRIES] && (last.func == FUNC_PUT) &&
                     !last.hit && last.free_seen;
  assign alloc.key = last.key;
  assign alloc.mac = last.mac;
  assign alloc_idx = free_idx[TABLE_ENTRIES];

  // Work out the status of the finished token
  always_comb begin
    unique case (last.func)
      FUNC_PUT:        res_status = (last.hit || last.free_seen) ? ST_OK : ST_FULL;
      FUNC_LOOKUP:     res_status = last.hit ? ST_OK : ST_NOT_FOUND;
      FUNC_INVALIDATE: res_status = last.hit ? ST_OK : ST_NOT_FOUND;
      default:         res_status = ST_OK;
    endcase
  end

  assign hold_move = hold_valid && (!out_valid || !out_stall);

  // Handshake control: busy, hold and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (hold_move) begin
        busy <= 1'b0;
      end
      if (tok_valid[TABLE_ENTRIES]) begin
        hold_valid <= 1'b1;
      end else if (hold_move) begin
        hold_valid <= 1'b0;
      end
      if (hold_move) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: hold, then advance to the output word
  always_ff @(posedge clk) begin
    if (tok_valid[TABLE_ENTRIES]) begin
      hold_status <= res_status;
      hold_mac    <= last.found_mac;
    end
    if (hold_move) begin
      status    <= hold_status;
      mac_found <= hold_mac;
    end
  end

  // At most one token travels the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid))
    else $error("more than one token in the cell row");

  // An idle block has nothing in flight
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (tok_valid[TABLE_ENTRIES:1] == '0) && !hold_valid)
    else $error("token or held result while not busy");

  // Accepting a word marks the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && tok_valid[1])
    else $error("accepted word not launched");

  // A held result is not lost while the output is stalled
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    hold_valid && out_valid && out_stall |=> hold_valid && $stable(hold_status))
    else $error("held result dropped under stall");

endmodule

`default_nettype wire

// ----- test/arp_address_cache_tb.sv -----
// Self-checking testbench for arp_address_cache: directed and random put, lookup and
// invalidate words, each checked against a behavioral table kept inside the testbench.
// Depends on arpc_pkg and the arp_address_cache RTL.
module arp_address_cache_tb;
  import arpc_pkg::*;

  localparam int ENTRIES = 16;
  // Operation code the block ignores
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [MAC_W-1:0]    mac;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   func = FUNC_LOOKUP;
  logic [IPV4_W-1:0]   ipv4_addr = '0;
  logic [MAC_W-1:0]    mac_addr = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [MAC_W-1:0]    mac_found;

  // Behavioral copy of the cache
  bit                slot_valid [ENTRIES];
  logic [IPV4_W-1:0] slot_ipv4 [ENTRIES];
  logic [MAC_W-1:0]  slot_mac [ENTRIES];

  reply_t pending_replies [$];
  int     mismatches = 0;
  int     gap_max = 18;
  int     stall_max = 18;
  int     stall_left = 0;

  arp_address_cache #(.TABLE_ENTRIES(ENTRIES)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .ipv4_addr (ipv4_addr),
    .mac_addr  (mac_addr),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .mac_found (mac_found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the table copy and return the reply it yields
  function automatic reply_t cache_apply(logic [FUNC_W-1:0] op, logic [IPV4_W-1:0] key,
                                         logic [MAC_W-1:0] mac);
    reply_t r;
    int     hit;
    int     free_slot;
    r.status  = ST_OK;
    r.mac     = '0;
    hit       = -1;
    free_slot = -1;
    // Scan downward so the lowest match and the lowest free slot win
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (slot_valid[k] && slot_ipv4[k] == key) hit = k;
      if (!slot_valid[k]) free_slot = k;
    end
    case (op)
      FUNC_PUT: begin
        if (hit >= 0) begin
          slot_mac[hit] = mac;
        end else if (free_slot >= 0) begin
          slot_valid[free_slot] = 1'b1;
          slot_ipv4[free_slot]  = key;
          slot_mac[free_slot]   = mac;
        end else begin
          r.status = ST_FULL;
        end
      end
      FUNC_LOOKUP: begin
        if (hit >= 0) r.mac = slot_mac[hit];
        else r.status = ST_NOT_FOUND;
      end
      FUNC_INVALIDATE: begin
        if (hit >= 0) slot_valid[hit] = 1'b0;
        else r.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // Send one word, then record the reply it must produce
  task automatic send_word(logic [FUNC_W-1:0] op, logic [IPV4_W-1:0] key,
                           logic [MAC_W-1:0] mac);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= op;
    ipv4_addr <= key;
    mac_addr  <= mac;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_replies.push_back(cache_apply(op, key, mac));
  endtask

  // Drain replies with random stalls and compare each against the oldest prediction
  always @(posedge clk) begin : reply_drain
    reply_t want;
    int     hold;
    hold = stall_left;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: status %0d mac_found %h", status, mac_found);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (mac_found !== want.mac) begin
          $error("mac_found: expected %h, got %h", want.mac, mac_found);
          mismatches++;
        end
      end
      hold = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
    end else if (hold != 0) begin
      hold--;
    end
    stall_left <= hold;
    out_stall  <= !rst && hold != 0;
  end

  // Miss on an empty table at both key extremes
  task automatic test_empty_table();
    send_word(FUNC_LOOKUP, '0, '1);
    send_word(FUNC_INVALIDATE, '1, '0);
  endtask

  // Fill every entry, overflow, then overwrite while full
  task automatic test_fill_to_full(output logic [IPV4_W-1:0] keys [ENTRIES]);
    logic [MAC_W-1:0] mac;
    for (int k = 0; k < ENTRIES; k++) begin
      keys[k] = (k == 0) ? '0 : (k == ENTRIES - 1) ? '1 : $urandom();
      mac     = (k == 0) ? '0 : (k == ENTRIES - 1) ? '1 : rand_mac();
      send_word(FUNC_PUT, keys[k], mac);
    end
    send_word(FUNC_PUT, 32'h0a00_0001, rand_mac());
    send_word(FUNC_PUT, keys[0], '1);
    send_word(FUNC_LOOKUP, keys[0], '0);
  endtask

  // Free a middle entry, miss on it, then reuse the hole
  task automatic test_invalidate_and_reuse(input logic [IPV4_W-1:0] keys [ENTRIES]);
    send_word(FUNC_INVALIDATE, keys[5], rand_mac());
    send_word(FUNC_INVALIDATE, keys[5], rand_mac());
    send_word(FUNC_PUT, 32'hc0a8_0001, rand_mac());
    send_word(FUNC_LOOKUP, 32'hc0a8_0001, rand_mac());
  endtask

  task automatic test_unused_func();
    send_word(FUNC_UNUSED, '1, '1);
  endtask

  // Mixed traffic over a small key pool so entries hit, fill up and free again
  task automatic test_random_traffic(int items, int pool_size, int idle_in, int idle_out);
    logic [IPV4_W-1:0] pool [$];
    logic [FUNC_W-1:0] op;
    logic [IPV4_W-1:0] key;
    int                pick;
    gap_max   = idle_in;
    stall_max = idle_out;
    repeat (pool_size) pool.push_back($urandom());
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) op = FUNC_PUT;
      else if (pick < 75) op = FUNC_LOOKUP;
      else if (pick < 97) op = FUNC_INVALIDATE;
      else op = FUNC_UNUSED;
      key = ($urandom_range(0, 19) == 0) ? $urandom() : pool[$urandom_range(0, pool_size - 1)];
      send_word(op, key, rand_mac());
    end
  endtask

  initial begin
    logic [IPV4_W-1:0] fill_keys [ENTRIES];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_fill_to_full(fill_keys);
    test_invalidate_and_reuse(fill_keys);
    test_unused_func();
    test_random_traffic(330, 24, 18, 18);
    test_random_traffic(330, 6, 0, 0);
    test_random_traffic(330, 40, 18, 0);
    test_random_traffic(330, 20, 0, 18);
    test_random_traffic(310, 18, 18, 18);

    // Drop valid and let the last replies drain
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (2 * ENTRIES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
